@@ hdl/char_buffer_mark_retract_core_defines.svh @@
// Assertion macros shared by the character buffer modules
`ifndef CHAR_BUFFER_MARK_RETRACT_CORE_DEFINES_SVH
`define CHAR_BUFFER_MARK_RETRACT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CBMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CBMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cbmr_pkg.sv @@
// Types and constants of the character buffer with mark and retract
`default_nettype none

package cbmr_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 8;
    localparam int POS_W  = 13;
    localparam int CHAR_W = 7;
    localparam int ERR_W  = 16;
    localparam int SUM_W  = 8;
    localparam int HIST_W = 13;

    localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};
    localparam logic [ERR_W-1:0]  ERR_MAX  = {ERR_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 3'd0,
        CMD_GET     = 3'd1,
        CMD_RETRACT = 3'd2,
        CMD_RESTORE = 3'd3,
        CMD_MARK    = 3'd4,
        CMD_RECOVER = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_HIST    = 3'd7
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] data_char;
        logic [POS_W-1:0]  mark_value;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [CHAR_W-1:0] read_char;
        logic              end_flag;
        logic              empty_flag;
        logic              full_flag;
        logic [POS_W-1:0]  read_position;
        logic [POS_W-1:0]  write_position;
        logic [POS_W-1:0]  mark_position;
        logic [ERR_W-1:0]  error_count;
        logic [SUM_W-1:0]  checksum;
        logic [HIST_W-1:0] hist_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

endpackage

`default_nettype wire

@@ hdl/cbmr_ctrl.sv @@
// Controller: request capture, execute sequencing and result valid
`default_nettype none
`include "char_buffer_mark_retract_core_defines.svh"

module cbmr_ctrl
    import cbmr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    output logic       res_valid,
    input  wire logic  res_ready,
    output ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   slot_free;

    assign slot_free = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        req_ready    = (state_reg == ST_IDLE);
        ctrl.capture = (state_reg == ST_IDLE) && req_valid;
        ctrl.execute = (state_reg == ST_EXEC) && slot_free;
        if (ctrl.execute)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;

    `CBMR_ASSERT_NEXT(a_exec_gives_result, ctrl.execute, res_valid_reg, "execute without result")
    `CBMR_ASSERT_NEXT(a_capture_then_exec, ctrl.capture, state_reg == ST_EXEC, "capture lost")
    `CBMR_ASSERT_NOW(a_exec_free_slot, ctrl.execute, !res_valid_reg || res_ready, "result overrun")

endmodule

`default_nettype wire

@@ hdl/cbmr_dpath.sv @@
// Datapath: positions, character store, histogram and result register
`default_nettype none
`include "char_buffer_mark_retract_core_defines.svh"

module cbmr_dpath
    import cbmr_pkg::*;
#(
    parameter int CAPACITY = 4096,
    parameter int ALPHABET = 128
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctrl_t ctrl,
    input  wire req_t  req,
    output rsp_t       res
);

    localparam int PW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(ALPHABET);
    localparam int CMPW = (PW > POS_W) ? PW : POS_W;
    localparam logic [DATA_W:0] ALPHA_LIM = (DATA_W + 1)'(ALPHABET);
    localparam logic [PW-1:0]   CAP_POS   = PW'(CAPACITY);

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] char_reg;
    logic [POS_W-1:0]  mark_val_reg;

    logic [PW-1:0]     wr_pos_reg;
    logic [PW-1:0]     wr_pos_next;
    logic [PW-1:0]     rd_pos_reg;
    logic [PW-1:0]     rd_pos_next;
    logic [PW-1:0]     mark_pos_reg;
    logic [PW-1:0]     mark_pos_next;
    logic              end_reg;
    logic              end_next;
    logic [ERR_W-1:0]  err_reg;
    logic [ERR_W-1:0]  err_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    logic [CW-1:0]     store_mem [CAPACITY];
    logic [CW-1:0]     store_rd_reg;
    logic [HIST_W-1:0] hist_mem [ALPHABET];
    logic [HIST_W-1:0] hist_rd_reg;
    logic              hist_rd_vld_reg;
    logic [ALPHABET-1:0] hist_vld_reg;

    logic              ok;
    logic [CHAR_W-1:0] rch;
    logic [HIST_W-1:0] hist_out;
    logic [HIST_W-1:0] hist_val;
    logic [HIST_W-1:0] hist_inc;
    logic              char_ok;
    logic              full;
    logic              add_we;
    logic              hist_clr;
    rsp_t              res_reg;

    assign char_ok  = {1'b0, char_reg} < ALPHA_LIM;
    assign full     = (wr_pos_reg == CAP_POS);
    assign hist_val = hist_rd_vld_reg ? hist_rd_reg : '0;
    assign hist_inc = (hist_val == HIST_MAX) ? hist_val : hist_val + HIST_W'(1);

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg         <= req.cmd;
            char_reg        <= req.data_char;
            mark_val_reg    <= req.mark_value;
            store_rd_reg    <= store_mem[rd_pos_reg[AW-1:0]];
            hist_rd_reg     <= hist_mem[req.data_char[CW-1:0]];
            hist_rd_vld_reg <= hist_vld_reg[req.data_char[CW-1:0]];
        end
        if (ctrl.execute && add_we)
        begin
            store_mem[wr_pos_reg[AW-1:0]] <= char_reg[CW-1:0];
            hist_mem[char_reg[CW-1:0]]    <= hist_inc;
        end
        if (ctrl.execute)
        begin
            res_reg.ok             <= ok;
            res_reg.read_char      <= rch;
            res_reg.end_flag       <= end_next;
            res_reg.empty_flag     <= (wr_pos_next == '0);
            res_reg.full_flag      <= (wr_pos_next == CAP_POS);
            res_reg.read_position  <= POS_W'(rd_pos_next);
            res_reg.write_position <= POS_W'(wr_pos_next);
            res_reg.mark_position  <= POS_W'(mark_pos_next);
            res_reg.error_count    <= err_next;
            res_reg.checksum       <= sum_next;
            res_reg.hist_count     <= hist_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            mark_pos_reg <= '0;
            end_reg      <= 1'b0;
            err_reg      <= '0;
            sum_reg      <= '0;
            hist_vld_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            wr_pos_reg   <= wr_pos_next;
            rd_pos_reg   <= rd_pos_next;
            mark_pos_reg <= mark_pos_next;
            end_reg      <= end_next;
            err_reg      <= err_next;
            sum_reg      <= sum_next;
            if (hist_clr)
            begin
                hist_vld_reg <= '0;
            end
            else if (add_we)
            begin
                hist_vld_reg[char_reg[CW-1:0]] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        ok            = 1'b1;
        rch           = '0;
        hist_out      = '0;
        wr_pos_next   = wr_pos_reg;
        rd_pos_next   = rd_pos_reg;
        mark_pos_next = mark_pos_reg;
        end_next      = end_reg;
        err_next      = err_reg;
        sum_next      = sum_reg;
        add_we        = 1'b0;
        hist_clr      = 1'b0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (!char_ok)
                begin
                    if (err_reg != ERR_MAX)
                    begin
                        err_next = err_reg + ERR_W'(1);
                    end
                end
                else if (full)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    add_we      = 1'b1;
                    wr_pos_next = wr_pos_reg + PW'(1);
                    sum_next    = sum_reg + char_reg;
                    end_next    = 1'b0;
                end
            end
            CMD_GET:
            begin
                if (rd_pos_reg < wr_pos_reg)
                begin
                    rch         = CHAR_W'(store_rd_reg);
                    rd_pos_next = rd_pos_reg + PW'(1);
                    end_next    = 1'b0;
                end
                else
                begin
                    end_next = 1'b1;
                end
            end
            CMD_RETRACT:
            begin
                if (rd_pos_reg == '0)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    rd_pos_next = rd_pos_reg - PW'(1);
                    end_next    = 1'b0;
                end
            end
            CMD_RESTORE:
            begin
                rd_pos_next = mark_pos_reg;
                end_next    = 1'b0;
            end
            CMD_MARK:
            begin
                if (CMPW'(mark_val_reg) > CMPW'(wr_pos_reg))
                begin
                    ok = 1'b0;
                end
                else
                begin
                    mark_pos_next = PW'(mark_val_reg);
                end
            end
            CMD_RECOVER:
            begin
                rd_pos_next   = '0;
                mark_pos_next = '0;
                end_next      = 1'b0;
            end
            CMD_CLEAR:
            begin
                wr_pos_next   = '0;
                rd_pos_next   = '0;
                mark_pos_next = '0;
                end_next      = 1'b0;
                err_next      = '0;
                sum_next      = '0;
                hist_clr      = 1'b1;
            end
            CMD_HIST:
            begin
                if (!char_ok)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    hist_out = hist_val;
                end
            end
        endcase
    end

    assign res = res_reg;

    `CBMR_ASSERT_NOW(a_rd_within_wr, 1'b1, rd_pos_reg <= wr_pos_reg, "read beyond write")
    `CBMR_ASSERT_NOW(a_mark_within_wr, 1'b1, mark_pos_reg <= wr_pos_reg, "mark beyond write")
    `CBMR_ASSERT_NOW(a_wr_within_cap, 1'b1, wr_pos_reg <= CAP_POS, "write beyond capacity")
    `CBMR_ASSERT_NEXT(a_clear_hist, ctrl.execute && hist_clr, hist_vld_reg == '0, "clear missed")

endmodule

`default_nettype wire

@@ hdl/char_buffer_mark_retract_core.sv @@
// Top level of the character buffer with mark and retract
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------------------
//  request | req_valid | req_ready | req (cmd, data_char, mark_value)
//  result  | res_valid | res_ready | res (ok ... hist_count)
//
//  Each request is taken as a capture with memory read, then an execute
//  with memory write-back; a new request is accepted only after the last executes.
//  The capture-read of the store and histogram and its write-back set the pace.
//  A result waits in an output register; the next request is captured meanwhile.
//  Execute stalls while a previous result is still held.
//  Reset clears positions, counters and histogram valid flags; no clearing pass.
`default_nettype none

module char_buffer_mark_retract_core
    import cbmr_pkg::*;
#(
    parameter int CAPACITY = 4096,
    parameter int ALPHABET = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      res_valid,
    input  wire logic res_ready,
    output rsp_t      res
);

    ctrl_t ctrl;

    cbmr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ctrl      (ctrl)
    );

    cbmr_dpath #(
        .CAPACITY (CAPACITY),
        .ALPHABET (ALPHABET)
    ) u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .res   (res)
    );

endmodule

`default_nettype wire

@@ tb/tb_char_buffer_mark_retract_core.sv @@
// Self-checking testbench for the character buffer with mark and retract
`timescale 1ns / 1ps

module tb_char_buffer_mark_retract_core;
    import cbmr_pkg::*;

    localparam int BUF_CAP     = 4096;
    localparam int BUF_ALPHA   = 128;
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_REQS = 830;

    class cbmr_scoreboard;
        logic [CHAR_W-1:0] char_mem [BUF_CAP];
        logic [HIST_W-1:0] char_tally [BUF_ALPHA];
        logic [POS_W-1:0]  wr_at;
        logic [POS_W-1:0]  rd_at;
        logic [POS_W-1:0]  mark_at;
        logic              at_end;
        logic [ERR_W-1:0]  rejects;
        logic [SUM_W-1:0]  sum;
        rsp_t              status_queue[$];
        int unsigned       mismatches;

        function new();
            wipe();
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (char_tally[i])
            begin
                char_tally[i] = '0;
            end
            wr_at   = '0;
            rd_at   = '0;
            mark_at = '0;
            at_end  = 1'b0;
            rejects = '0;
            sum     = '0;
        endfunction

        function void note_command(req_t r);
            rsp_t              want;
            logic [CHAR_W-1:0] ch;
            want    = '0;
            want.ok = 1'b1;
            ch      = r.data_char[CHAR_W-1:0];
            unique case (r.cmd)
                CMD_ADD:
                begin
                    if (r.data_char >= BUF_ALPHA)
                    begin
                        if (rejects != ERR_MAX)
                            rejects++;
                    end
                    else if (wr_at >= BUF_CAP)
                    begin
                        want.ok = 1'b0;
                    end
                    else
                    begin
                        char_mem[wr_at] = ch;
                        wr_at++;
                        sum = sum + r.data_char;
                        if (char_tally[ch] != HIST_MAX)
                            char_tally[ch]++;
                        at_end = 1'b0;
                    end
                end
                CMD_GET:
                begin
                    if (rd_at >= wr_at)
                    begin
                        at_end = 1'b1;
                    end
                    else
                    begin
                        want.read_char = char_mem[rd_at];
                        rd_at++;
                        at_end = 1'b0;
                    end
                end
                CMD_RETRACT:
                begin
                    if (rd_at == 0)
                    begin
                        want.ok = 1'b0;
                    end
                    else
                    begin
                        rd_at--;
                        at_end = 1'b0;
                    end
                end
                CMD_RESTORE:
                begin
                    rd_at  = mark_at;
                    at_end = 1'b0;
                end
                CMD_MARK:
                begin
                    if (r.mark_value > wr_at)
                        want.ok = 1'b0;
                    else
                        mark_at = r.mark_value;
                end
                CMD_RECOVER:
                begin
                    rd_at   = '0;
                    mark_at = '0;
                    at_end  = 1'b0;
                end
                CMD_CLEAR:
                begin
                    wipe();
                end
                CMD_HIST:
                begin
                    if (r.data_char >= BUF_ALPHA)
                        want.ok = 1'b0;
                    else
                        want.hist_count = char_tally[ch];
                end
            endcase
            want.end_flag       = at_end;
            want.empty_flag     = (wr_at == 0);
            want.full_flag      = (wr_at == BUF_CAP);
            want.read_position  = rd_at;
            want.write_position = wr_at;
            want.mark_position  = mark_at;
            want.error_count    = rejects;
            want.checksum       = sum;
            status_queue.push_back(want);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0d, got %0d", what, want, got);
            end
        endfunction

        function void check_status(rsp_t got);
            rsp_t want;
            if (status_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request outstanding: %p", got);
                return;
            end
            want = status_queue.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("read_char", want.read_char, got.read_char);
            compare_field("end_flag", want.end_flag, got.end_flag);
            compare_field("empty_flag", want.empty_flag, got.empty_flag);
            compare_field("full_flag", want.full_flag, got.full_flag);
            compare_field("read_position", want.read_position, got.read_position);
            compare_field("write_position", want.write_position, got.write_position);
            compare_field("mark_position", want.mark_position, got.mark_position);
            compare_field("error_count", want.error_count, got.error_count);
            compare_field("checksum", want.checksum, got.checksum);
            compare_field("hist_count", want.hist_count, got.hist_count);
        endfunction
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    rsp_t res;

    cbmr_scoreboard sb = new();
    int             burst_left = 0;
    bit             hold_results = 1'b0;

    char_buffer_mark_retract_core #(
        .CAPACITY (BUF_CAP),
        .ALPHABET (BUF_ALPHA)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_command(req);
            if (res_valid && res_ready)
                sb.check_status(res);
        end
    end

    initial
    begin
        int         mode;
        int         tick;
        logic [7:0] pattern;
        mode    = 0;
        tick    = 0;
        pattern = 8'b1101_0110;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                tick++;
                if (tick % 150 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: res_ready <= 1'b1;
                    1:
                    begin
                        res_ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                    2: res_ready <= ($urandom_range(0, 3) != 0);
                    default: res_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    function automatic req_t make_req(cmd_t c, int unsigned ch, int unsigned mv);
        req_t r;
        r.cmd        = c;
        r.data_char  = ch[DATA_W-1:0];
        r.mark_value = mv[POS_W-1:0];
        return r;
    endfunction

    function automatic req_t random_command();
        int   roll;
        req_t r;
        roll = $urandom_range(0, 99);
        r    = make_req(CMD_ADD, $urandom_range(0, 255), $urandom_range(0, 8191));
        if (roll < 34)
        begin
            if ($urandom_range(0, 7) != 0)
                r.data_char[7] = 1'b0;
        end
        else if (roll < 60)
        begin
            r.cmd = CMD_GET;
        end
        else if (roll < 68)
        begin
            r.cmd = CMD_RETRACT;
        end
        else if (roll < 74)
        begin
            r.cmd = CMD_RESTORE;
        end
        else if (roll < 83)
        begin
            r.cmd = CMD_MARK;
            if ($urandom_range(0, 3) != 0)
                r.mark_value = POS_W'($urandom_range(0, sb.wr_at));
        end
        else if (roll < 87)
        begin
            r.cmd = CMD_RECOVER;
        end
        else if (roll < 89)
        begin
            r.cmd = CMD_CLEAR;
        end
        else
        begin
            r.cmd = CMD_HIST;
            if ($urandom_range(0, 7) != 0)
                r.data_char[7] = 1'b0;
        end
        return r;
    endfunction

    task automatic send_req(input req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic issue(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        send_req(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.status_queue.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_RETRACT, 255, 8191));
        issue(make_req(CMD_ADD, 0, 0));
        issue(make_req(CMD_ADD, 127, 0));
        issue(make_req(CMD_ADD, 128, 0));
        issue(make_req(CMD_ADD, 255, 8191));
        issue(make_req(CMD_HIST, 0, 0));
        issue(make_req(CMD_HIST, 127, 0));
        issue(make_req(CMD_HIST, 128, 0));
        issue(make_req(CMD_HIST, 255, 0));
        issue(make_req(CMD_MARK, 0, 1));
        issue(make_req(CMD_MARK, 0, 3));
        issue(make_req(CMD_MARK, 0, 8191));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_RETRACT, 0, 0));
        issue(make_req(CMD_RESTORE, 0, 0));
        issue(make_req(CMD_MARK, 0, 2));
        issue(make_req(CMD_RECOVER, 0, 0));
        issue(make_req(CMD_ADD, 85, 0));
        issue(make_req(CMD_CLEAR, 0, 0));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_MARK, 0, 0));

        for (i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == RANDOM_REQS / 3)
            begin
                hold_results = 1'b1;
                repeat (12) send_req(random_command());
            end
            if (i == 2 * RANDOM_REQS / 3)
                wait_drained();
            issue(random_command());
        end

        // walk the mark bounds and the end of data on a short buffer
        issue(make_req(CMD_CLEAR, 0, 0));
        repeat (8) issue(make_req(CMD_ADD, $urandom_range(0, 127), 0));
        issue(make_req(CMD_ADD, 200, 0));
        issue(make_req(CMD_HIST, $urandom_range(0, 127), 0));
        issue(make_req(CMD_MARK, 0, 9));
        issue(make_req(CMD_MARK, 0, 8));
        issue(make_req(CMD_RESTORE, 0, 0));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_RETRACT, 0, 0));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_RECOVER, 0, 0));
        repeat (12) issue(make_req(CMD_GET, 0, 0));
        issue(make_req(CMD_CLEAR, 0, 0));
        issue(make_req(CMD_ADD, 1, 0));
        issue(make_req(CMD_HIST, 1, 0));
        issue(make_req(CMD_CLEAR, 0, 0));

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.status_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
